[rtl/color_bar_gradient_pattern_assert.svh]
// assertion macros for the checker file of the pattern generator
`ifndef COLOR_BAR_GRADIENT_PATTERN_ASSERT_SVH
`define COLOR_BAR_GRADIENT_PATTERN_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define CBG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbg assertion failed");

// next-cycle implication, ignored while reset is high
`define CBG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbg assertion failed");

`endif

[rtl/cbg_pkg.sv]
// types, constants and colour table of the colour bar pattern generator
package cbg_pkg;

   localparam int COORD_BITS      = 12;
   localparam int DIM_BITS        = 12;
   localparam int CHAN_BITS       = 8;
   localparam int NUM_BARS        = 8;
   localparam int BAR_IDX_BITS    = $clog2(NUM_BARS);
   localparam int CMP_BITS        = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
   localparam int NUM_BITS        = DIM_BITS + CHAN_BITS;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = CHAN_BITS / STEPS_PER_STAGE;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = DIM_BITS;

   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = DIM_BITS'(780);
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = DIM_BITS'(580);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_PATTERN_MODE = 2'd2
   } csr_index_type;

   // channel enables per bar, {red, green, blue}; a lit channel carries the faded level
   localparam logic [2:0] BAR_MASK [NUM_BARS] = '{
      3'b111,  // white
      3'b100,  // red
      3'b010,  // green
      3'b001,  // blue
      3'b011,  // cyan
      3'b101,  // pink
      3'b110,  // yellow
      3'b000   // black
   };

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } rsp_type;

   // state of the restoring divider as it moves down the pipeline
   typedef struct packed {
      logic [2:0]           chan_mask;
      logic [DIM_BITS-1:0]  divisor;
      logic [DIM_BITS-1:0]  rem;
      logic [CHAN_BITS-1:0] num;
      logic [CHAN_BITS-1:0] quot;
   } div_type;

endpackage

[rtl/cbg_div_stage.sv]
// one pipeline stage of the restoring divider for the vertical fade
module cbg_div_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  logic            in_valid,
   input  cbg_pkg::div_type in_data,
   output logic            out_valid,
   output cbg_pkg::div_type out_data
);
   import cbg_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   always_comb begin
      div_type             work;
      logic [DIM_BITS:0]   trial;
      logic                take;
      work = in_data;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         trial     = {work.rem, work.num[CHAN_BITS-1]};
         take      = trial >= {1'b0, work.divisor};
         work.rem  = take ? DIM_BITS'(trial - {1'b0, work.divisor}) : trial[DIM_BITS-1:0];
         work.num  = {work.num[CHAN_BITS-2:0], 1'b0};
         work.quot = {work.quot[CHAN_BITS-2:0], take};
      end
      data_in = work;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/color_bar_gradient_pattern.sv]
// colour bar test pattern generator, top level
// five register stages between the pixel request and the colour on rsp_
// throughput: one pixel per clock; a front stage finds the bar, then four
// divider stages of two quotient bits each work out the fade
// the whole pipeline holds while a finished beat waits on rsp_ready
// reset clears all valid bits and loads width 780, height 580, mode black
module color_bar_gradient_pattern (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cbg_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cbg_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wen,
   input  logic [cbg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cbg_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import cbg_pkg::*;

   // configuration registers
   logic [DIM_BITS-1:0] frame_width_ff,  frame_width_in;
   logic [DIM_BITS-1:0] frame_height_ff, frame_height_in;
   logic                pattern_mode_ff, pattern_mode_in;

   // front stage results
   logic [DIM_BITS-BAR_IDX_BITS-1:0] bar_w;
   logic [DIM_BITS-1:0]              bars_end;
   logic [CMP_BITS-1:0]              x_ext, y_ext, h_ext;
   logic [NUM_BARS-2:0]              past_edge;
   logic [BAR_IDX_BITS-1:0]          bar_idx;
   logic                             lit;
   logic [DIM_BITS-1:0]              rows_left;
   logic [NUM_BITS-1:0]              numer;
   div_type                          front_in;

   // pipeline: index 0 is the front stage, the last one is the output register
   logic    stage_valid [DIV_STAGES+1];
   div_type stage_data  [DIV_STAGES+1];
   logic    advance;
   div_type last;

   // register writes, an index past the list is dropped
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      pattern_mode_in = pattern_mode_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata[DIM_BITS-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[DIM_BITS-1:0];
            CSR_PATTERN_MODE: pattern_mode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         pattern_mode_ff <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         pattern_mode_ff <= pattern_mode_in;
      end
   end

   // whole pipeline moves unless the output beat is stuck
   assign advance   = !stage_valid[DIV_STAGES] || rsp_ready;
   assign req_ready = advance;

   // bar lookup: count the bar edges at or left of x instead of dividing
   always_comb begin
      bar_w    = frame_width_ff[DIM_BITS-1:BAR_IDX_BITS];
      // eight full bars end here, zero when the frame is narrower than eight
      bars_end = {bar_w, BAR_IDX_BITS'(0)};
      x_ext    = CMP_BITS'(req_data.pixel_x);
      y_ext    = CMP_BITS'(req_data.pixel_y);
      h_ext    = CMP_BITS'(frame_height_ff);
      bar_idx  = '0;
      for (int k = 1; k < NUM_BARS; k++) begin
         past_edge[k-1] = x_ext >= CMP_BITS'(bar_w * k);
      end
      for (int k = 0; k < NUM_BARS - 1; k++) begin
         bar_idx = bar_idx + BAR_IDX_BITS'(past_edge[k]);
      end
      // inside the bars also means inside the frame width; zero height never lit
      lit = pattern_mode_ff && (x_ext < CMP_BITS'(bars_end)) && (y_ext < h_ext);
      // only meaningful when lit, then it is below the height
      rows_left = DIM_BITS'(h_ext - y_ext - CMP_BITS'(1));
      // full scale 255 times rows left, as a shift and subtract
      numer = NUM_BITS'({rows_left, CHAN_BITS'(0)}) - NUM_BITS'(rows_left);
      front_in.chan_mask = lit ? BAR_MASK[bar_idx] : 3'b000;
      front_in.divisor   = frame_height_ff;
      // quotient fits in eight bits, so the top part is already below the divisor
      front_in.rem       = numer[NUM_BITS-1:CHAN_BITS];
      front_in.num       = numer[CHAN_BITS-1:0];
      front_in.quot      = '0;
   end

   logic    front_valid_ff;
   div_type front_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (advance) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_data_ff <= front_in;
      end
   end

   assign stage_valid[0] = front_valid_ff;
   assign stage_data[0]  = front_data_ff;

   // fade divider, two quotient bits per stage
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      cbg_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   // last divider register doubles as the output register
   assign last           = stage_data[DIV_STAGES];
   assign rsp_valid      = stage_valid[DIV_STAGES];
   assign rsp_data.red   = last.chan_mask[2] ? last.quot : '0;
   assign rsp_data.green = last.chan_mask[1] ? last.quot : '0;
   assign rsp_data.blue  = last.chan_mask[0] ? last.quot : '0;

endmodule

[rtl/cbg_checker.sv]
// port-level checker for the pattern generator and its bind
`include "color_bar_gradient_pattern_assert.svh"

module cbg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cbg_pkg::rsp_type rsp_data
);
   import cbg_pkg::*;

   localparam logic [CHAN_BITS-1:0] FULL_SCALE = '1;

   logic rsp_stalled;
   logic below_full;
   logic red_green_match;
   logic green_blue_match;

   assign rsp_stalled      = rsp_valid && !rsp_ready;
   assign below_full       = rsp_data.red != FULL_SCALE && rsp_data.green != FULL_SCALE &&
                             rsp_data.blue != FULL_SCALE;
   assign red_green_match  = rsp_data.red == rsp_data.green || rsp_data.red == '0 ||
                             rsp_data.green == '0;
   assign green_blue_match = rsp_data.green == rsp_data.blue || rsp_data.green == '0 ||
                             rsp_data.blue == '0;

   // a stalled result beat holds its colour
   `CBG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_data))

   // with no result waiting the block always takes a pixel
   `CBG_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // the fade keeps every channel below full scale
   `CBG_ASSERT_NOW(a_no_full_scale, clock, reset, rsp_valid, below_full)

   // lit channels of one pixel share the same faded level
   `CBG_ASSERT_NOW(a_shared_level, clock, reset, rsp_valid, red_green_match && green_blue_match)

endmodule

bind color_bar_gradient_pattern cbg_checker u_cbg_checker (.*);

[bench/color_bar_gradient_pattern_test.sv]
// self-checking bench for the colour bar pattern generator: directed probes then random frames
`timescale 1ns / 1ps

module color_bar_gradient_pattern_test;
   import cbg_pkg::*;

   // pattern modes and the spare register index that must be ignored
   localparam logic MODE_BLACK = 1'b0;
   localparam logic MODE_BARS  = 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   localparam int RESULT_LATENCY = 5;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_PIXELS   = 69;
   localparam int HOLD_CYCLES    = 80;
   localparam int IDLE_PERCENT   = 24;
   localparam int unsigned FULL_SCALE = 255;

   localparam rsp_type BLACK = '0;

   // lit channels per bar, {red, green, blue}, left to right
   localparam logic [2:0] BAR_CHANNELS [NUM_BARS] = '{
      3'b111, 3'b100, 3'b010, 3'b001, 3'b011, 3'b101, 3'b110, 3'b000
   };

   // directed probe: frame setting, pixel, and a typed-in colour where it is obvious
   localparam logic KNOWN   = 1'b1;
   localparam logic PREDICT = 1'b0;

   typedef struct packed {
      logic [DIM_BITS-1:0]   width;
      logic [DIM_BITS-1:0]   height;
      logic                  mode;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  known;
      rsp_type               want;
   } probe_row_type;

   localparam probe_row_type PROBES [22] = '{
      // straight out of reset the mode is black
      '{12'd780,  12'd580,  MODE_BLACK, 12'd0,    12'd0,    KNOWN,   BLACK},
      '{12'd780,  12'd580,  MODE_BLACK, 12'd4095, 12'd4095, KNOWN,   BLACK},
      '{12'd780,  12'd580,  MODE_BLACK, 12'd389,  12'd290,  KNOWN,   BLACK},
      // one pixel in each bar, fading further down the frame
      '{12'd800,  12'd580,  MODE_BARS,  12'd0,    12'd0,    PREDICT, BLACK},
      '{12'd800,  12'd580,  MODE_BARS,  12'd150,  12'd1,    PREDICT, BLACK},
      '{12'd800,  12'd580,  MODE_BARS,  12'd250,  12'd100,  PREDICT, BLACK},
      '{12'd800,  12'd580,  MODE_BARS,  12'd350,  12'd200,  PREDICT, BLACK},
      '{12'd800,  12'd580,  MODE_BARS,  12'd450,  12'd300,  PREDICT, BLACK},
      '{12'd800,  12'd580,  MODE_BARS,  12'd550,  12'd400,  PREDICT, BLACK},
      '{12'd800,  12'd580,  MODE_BARS,  12'd650,  12'd500,  PREDICT, BLACK},
      '{12'd800,  12'd580,  MODE_BARS,  12'd750,  12'd578,  PREDICT, BLACK},
      '{12'd800,  12'd580,  MODE_BARS,  12'd799,  12'd579,  PREDICT, BLACK},
      // just outside the frame, right and below
      '{12'd800,  12'd580,  MODE_BARS,  12'd800,  12'd0,    KNOWN,   BLACK},
      '{12'd800,  12'd580,  MODE_BARS,  12'd0,    12'd580,  KNOWN,   BLACK},
      // leftover columns past the eighth bar
      '{12'd804,  12'd580,  MODE_BARS,  12'd803,  12'd0,    KNOWN,   BLACK},
      // smallest legal frame
      '{12'd8,    12'd1,    MODE_BARS,  12'd7,    12'd0,    PREDICT, BLACK},
      // too narrow for eight bars
      '{12'd7,    12'd580,  MODE_BARS,  12'd0,    12'd0,    KNOWN,   BLACK},
      // largest frame
      '{12'd4095, 12'd4095, MODE_BARS,  12'd0,    12'd0,    PREDICT, BLACK},
      '{12'd4095, 12'd4095, MODE_BARS,  12'd3576, 12'd2048, PREDICT, BLACK},
      '{12'd4095, 12'd4095, MODE_BARS,  12'd4094, 12'd4094, PREDICT, BLACK},
      // zero height blanks the whole frame, and a pixel past the largest frame is black
      '{12'd4095, 12'd0,    MODE_BARS,  12'd0,    12'd0,    KNOWN,   BLACK},
      '{12'd4095, 12'd4095, MODE_BARS,  12'd4095, 12'd4095, KNOWN,   BLACK}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_data;
   logic                      csr_wen;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // our copy of the registers, updated once the writes of a new frame setting have gone in
   logic [DIM_BITS-1:0] frame_w = FRAME_WIDTH_RESET;
   logic [DIM_BITS-1:0] frame_h = FRAME_HEIGHT_RESET;
   logic                bars_on = MODE_BLACK;

   rsp_type expected_colours [$];
   int      mismatch_count = 0;
   int      idle_cycles = 0;
   bit      steady = 1'b0;        // no idling on either side
   bit      hold_request = 1'b0;  // asks the receiver for one long hold-off

   color_bar_gradient_pattern i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // colour of one pixel under the current register settings
   function automatic rsp_type paint_pixel(req_type px);
      int unsigned bar_w, bar, level, x, y, h;
      rsp_type colour;
      colour = BLACK;
      x = px.pixel_x;
      y = px.pixel_y;
      h = frame_h;
      bar_w = frame_w / NUM_BARS;
      if (bars_on == MODE_BARS && x < frame_w && y < h && bar_w != 0) begin
         bar = x / bar_w;
         // columns beyond the eighth bar stay black
         if (bar < NUM_BARS) begin
            level = (FULL_SCALE * (h - 1 - y)) / h;
            colour.red   = BAR_CHANNELS[bar][2] ? level[7:0] : 8'd0;
            colour.green = BAR_CHANNELS[bar][1] ? level[7:0] : 8'd0;
            colour.blue  = BAR_CHANNELS[bar][0] ? level[7:0] : 8'd0;
         end
      end
      return colour;
   endfunction

   // add one expected colour at the tail of the queue
   function automatic void queue_colour(rsp_type colour);
      expected_colours = {expected_colours, colour};
   endfunction

   // mostly pixels inside the frame, some just past an edge, the rest anywhere
   function automatic req_type pick_pixel();
      req_type px;
      int unsigned roll;
      roll = $urandom_range(99);
      px.pixel_x = COORD_BITS'($urandom);
      px.pixel_y = COORD_BITS'($urandom);
      if (roll < 75) begin
         px.pixel_x = (frame_w != 0) ? COORD_BITS'($urandom_range(frame_w - 1)) : '0;
         px.pixel_y = (frame_h != 0) ? COORD_BITS'($urandom_range(frame_h - 1)) : '0;
      end else if (roll < 88) begin
         if ($urandom_range(1))
            px.pixel_x = frame_w + COORD_BITS'($urandom_range(2));
         else
            px.pixel_y = frame_h + COORD_BITS'($urandom_range(2));
      end
      return px;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // new frame setting, only once the pipeline has drained
   task automatic set_frame(logic [DIM_BITS-1:0] width, logic [DIM_BITS-1:0] height,
                            logic mode);
      req_valid <= 1'b0;
      while (expected_colours.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 3) @(posedge clock);
      write_csr(CSR_FRAME_WIDTH, width);
      write_csr(CSR_FRAME_HEIGHT, height);
      // upper bits of the mode write are junk, only bit 0 counts
      write_csr(CSR_PATTERN_MODE, {(CSR_DATA_BITS-1)'($urandom), mode});
      write_csr(CSR_UNUSED, CSR_DATA_BITS'($urandom));
      csr_wen <= 1'b0;
      frame_w = width;
      frame_h = height;
      bars_on = mode;
   endtask

   // offer one pixel, hold it until taken, then note the colour it should give
   task automatic send_pixel(req_type px, logic known, rsp_type want);
      if (!steady)
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      queue_colour(known ? want : paint_pixel(px));
   endtask

   // stimulus
   initial begin
      req_type px;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_wen   <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed probes, reprogramming the frame only when the row asks for it
      foreach (PROBES[i]) begin
         if (PROBES[i].width != frame_w || PROBES[i].height != frame_h ||
             PROBES[i].mode != bars_on)
            set_frame(PROBES[i].width, PROBES[i].height, PROBES[i].mode);
         px.pixel_x = PROBES[i].x;
         px.pixel_y = PROBES[i].y;
         send_pixel(px, PROBES[i].known, PROBES[i].want);
      end

      // random pixels over a spread of frame settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_frame(12'd780, 12'd580, MODE_BARS);
            1: set_frame(12'd8, 12'd1, MODE_BARS);
            2: set_frame(12'd4095, 12'd4095, MODE_BARS);
            3: set_frame(12'($urandom_range(4095, 8)), 12'($urandom_range(4095, 1)),
                         MODE_BARS);
            4: set_frame(12'($urandom_range(4095, 8)), 12'($urandom_range(4095, 1)),
                         MODE_BLACK);
            5: set_frame(12'($urandom_range(64, 16)), 12'($urandom_range(16, 1)),
                         MODE_BARS);
            // degenerate: narrow frame, sometimes zero height as well
            6: set_frame(12'($urandom_range(7)),
                         $urandom_range(1) ? 12'd0 : 12'($urandom_range(4095, 1)),
                         MODE_BARS);
            default: set_frame(12'($urandom_range(4095, 8)), 12'($urandom_range(300, 1)),
                               MODE_BARS);
         endcase
         // one full-rate stretch with no idling anywhere
         steady = (phase == 2);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            // receiver backs off while we keep offering, so the pipeline fills
            if (phase == 3 && n == 10)
               hold_request = 1'b1;
            send_pixel(pick_pixel(), PREDICT, BLACK);
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // drain, then keep the clock running to catch any stray beat
      while (expected_colours.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 5) @(posedge clock);
      if (mismatch_count == 0 && expected_colours.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // receiver: checks each beat and drives rsp_ready for the next edge
   initial begin
      rsp_type want;
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_colours.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected colour beat r=%0d g=%0d b=%0d at %0t",
                           rsp_data.red, rsp_data.green, rsp_data.blue, $realtime);
            end else begin
               want = expected_colours.pop_front();
               if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                   rsp_data.blue !== want.blue) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("mismatch at %0t: expected r=%0d g=%0d b=%0d, got %0d %0d %0d",
                              $realtime, want.red, want.green, want.blue,
                              rsp_data.red, rsp_data.green, rsp_data.blue);
               end
            end
         end
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // watchdog: too long without a beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

endmodule

[color_bar_gradient_pattern.f]
+incdir+rtl
rtl/cbg_pkg.sv
rtl/cbg_div_stage.sv
rtl/color_bar_gradient_pattern.sv
rtl/cbg_checker.sv
bench/color_bar_gradient_pattern_test.sv
